[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SQ_ASSERT_ALWAYS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define SQ_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/sq8dvd_pkg.sv]
// Types, constants and helper functions of the SQ8 vector distance block.
`timescale 1ns / 1ps
package sq8dvd_pkg;

	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 64;
	localparam int NUM_W  = 96;
	localparam int ROOT_W = 32;

	// input word layout
	localparam int IN_W      = 104;
	localparam int OFS_QUERY = 0;
	localparam int OFS_CODE  = 32;
	localparam int OFS_MIN   = 40;
	localparam int OFS_STEP  = 72;
	localparam int CODE_W    = 8;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [2:0] MET_COSINE = 3'd0;
	localparam logic [2:0] MET_DOT    = 3'd1;
	localparam logic [2:0] MET_EUCLID = 3'd2;
	localparam logic [2:0] MET_MANHAT = 3'd3;
	localparam logic [2:0] MET_SQEUCL = 3'd4;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_ZERONORM = 2'd1;
	localparam logic [1:0] STAT_BADMET   = 2'd2;
	localparam logic [1:0] STAT_SAT      = 2'd3;

	localparam logic CFG_METRIC = 1'b0;
	localparam logic CFG_NORM   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_DEQ,
		ST_CROSS,
		ST_QSQ,
		ST_YSQ,
		ST_DSQ,
		ST_DIFF,
		ST_FIN,
		ST_SQRT_A,
		ST_SQRT_B,
		ST_DEN_MUL,
		ST_DEN,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                    sat;
		logic signed [ACC_W-1:0] val;
	} sres_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic sres_t sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		sres_t r;
		s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
		r.sat = (s[ACC_W] != s[ACC_W-1]);
		if (r.sat) begin
			r.val = s[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			r.val = s[ACC_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/sq8_dequant_vector_distance_top.sv]
// Top level: SQ8 dequantizing vector distance with its sequencer.
`timescale 1ns / 1ps
// One vector dimension is taken per input word (query, code, min, step, tlast on the last
// dimension). For each word the dequantize product and the cross and square products pass
// through one shared 34x34 multiplier, and the four accumulations through one saturating
// 64-bit adder, one step a cycle. On the last dimension the metric is formed: up to two
// square roots, one multiply and a divide for cosine, a root for euclidean, a root and a
// divide for normalised dot, and neither root nor divide for the others. s_axis_tready
// is low while a word or a result is in work. The result word waits in an output register,
// so the next vector may start while it is not yet taken. Distance is signed Q32.32, tuser
// carries the status (ok, zero norm, invalid metric, saturated).
module sq8_dequant_vector_distance_top #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// query_value[31:0], code_byte[39:32], level_min[71:40], level_step[103:72]
	input  logic [103:0] s_axis_tdata,
	input  logic         s_axis_tlast,   // last_element
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,   // distance[63:0]
	output logic [1:0]   m_axis_tuser,   // status[1:0]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [2:0]   cfg_data
);
	import sq8dvd_pkg::*;

	localparam int SH_Q1 = 32 - FRACTION_BITS;
	localparam int SH_Q2 = 32 - 2 * FRACTION_BITS;
	localparam logic signed [PROD_W-1:0] VMAX =
		PROD_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [PROD_W-1:0] VMIN = -VMAX - PROD_W'(1);
	localparam logic signed [ACC_W-1:0] ONE_Q32 = ACC_W'(1) << 32;

	function automatic sres_t scale_q(input logic signed [ACC_W-1:0] v, input int sh);
		logic signed [ACC_W-1:0] hi;
		sres_t r;
		r.sat = 1'b0;
		hi    = ACC_MAX >>> ((sh < 0) ? 0 : sh);
		if (sh < 0) begin
			r.val = v >>> (-sh);
		end else if (v > hi) begin
			r.sat = 1'b1;
			r.val = ACC_MAX;
		end else if (v < -hi - ACC_W'(1)) begin
			r.sat = 1'b1;
			r.val = ACC_MIN;
		end else begin
			r.val = v <<< sh;
		end
		return r;
	endfunction

	state_t state_q, state_d;

	logic [2:0] metric_q;
	logic       norm_q;

	logic signed [MUL_W-1:0] q_q, min_q, step_q, y_q;
	logic [CODE_W-1:0]       code_q;
	logic                    last_q;
	logic signed [ACC_W-1:0] cross_q, qe_q, ye_q, diff_q;
	logic                    sat_q;
	logic [ROOT_W-1:0]       nq_q;
	logic signed [ACC_W-1:0] res_dist_q;
	logic [1:0]              res_status_q;
	logic signed [ACC_W-1:0] out_dist_q;
	logic [1:0]              out_status_q;
	logic                    out_valid_q;

	// shared units
	logic                     mul_en;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     sq_start;
	logic [ACC_W-1:0]         sq_x;
	unit_stat_t               sq_stat;
	logic [ROOT_W-1:0]        sq_root;
	logic                     div_start;
	logic [NUM_W-1:0]         div_num;
	logic [ACC_W-1:0]         div_den;
	unit_stat_t               div_stat;
	logic [NUM_W-1:0]         div_quot;

	logic                    accept;
	logic                    out_free;
	logic signed [MUL_W-1:0] d_w;
	logic signed [ACC_W-1:0] add_a, add_b;
	sres_t                   add_r;
	logic signed [PROD_W-1:0] ysum;
	logic signed [ACC_W-1:0] prod64;
	logic [ACC_W-1:0]        mag;
	logic                    neg;
	logic                    use_ye;
	logic                    diff_sq, diff_abs;
	sres_t                   fin_r;
	logic                    fin_direct;
	logic                    zero_norm;
	logic                    cos_full;
	logic signed [ACC_W-1:0] cos_sim;
	logic signed [ACC_W-1:0] dot_q0;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign d_w       = q_q - y_q;
	assign prod64    = prod[ACC_W-1:0];
	assign add_r     = sat_add(add_a, add_b);
	assign ysum      = PROD_W'(min_q) + (prod >>> 1);
	assign neg       = cross_q[ACC_W-1];
	assign mag       = neg ? ACC_W'(-cross_q) : ACC_W'(cross_q);
	assign use_ye    = (metric_q == MET_COSINE) || (metric_q == MET_DOT && norm_q);
	assign diff_sq   = (metric_q == MET_EUCLID) || (metric_q == MET_SQEUCL);
	assign diff_abs  = (metric_q == MET_MANHAT);
	assign zero_norm = (sq_root == '0) || (metric_q == MET_COSINE && nq_q == '0);
	assign cos_full  = (mag >= ACC_W'(prod[ACC_W-1:0]));
	assign cos_sim   = ACC_W'(div_quot[32:0]);
	assign dot_q0    = div_quot[ACC_W-1:0];

	sq8dvd_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	sq8dvd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (sq_x),
		.stat   (sq_stat),
		.root   (sq_root)
	);

	sq8dvd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (accept) state_d = ST_SCALE;
			ST_SCALE:   state_d = ST_DEQ;
			ST_DEQ:     state_d = ST_CROSS;
			ST_CROSS:   state_d = ST_QSQ;
			ST_QSQ:     state_d = ST_YSQ;
			ST_YSQ:     state_d = ST_DSQ;
			ST_DSQ:     state_d = ST_DIFF;
			ST_DIFF:    state_d = last_q ? ST_FIN : ST_IDLE;
			ST_FIN: begin
				if (metric_q == MET_COSINE || metric_q == MET_EUCLID) begin
					state_d = ST_SQRT_A;
				end else if (metric_q == MET_DOT && norm_q) begin
					state_d = ST_SQRT_B;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_SQRT_A: begin
				if (sq_stat.done) begin
					state_d = (metric_q == MET_COSINE) ? ST_SQRT_B : ST_OUT;
				end
			end
			ST_SQRT_B: begin
				if (sq_stat.done) begin
					if (zero_norm) state_d = ST_OUT;
					else if (metric_q == MET_COSINE) state_d = ST_DEN_MUL;
					else state_d = ST_DIV;
				end
			end
			ST_DEN_MUL: state_d = ST_DEN;
			ST_DEN:     state_d = cos_full ? ST_OUT : ST_DIV;
			ST_DIV:     if (div_stat.done) state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		mul_en    = 1'b0;
		mul_a     = q_q;
		mul_b     = q_q;
		add_a     = cross_q;
		add_b     = prod64;
		sq_start  = 1'b0;
		sq_x      = '0;
		div_start = 1'b0;
		div_num   = {mag, 32'b0};
		div_den   = prod[ACC_W-1:0];
		unique case (state_q)
			ST_SCALE: begin
				mul_en = 1'b1;
				mul_a  = step_q;
				mul_b  = MUL_W'({code_q, 1'b1});
			end
			ST_CROSS: begin
				mul_en = 1'b1;
				mul_b  = y_q;
			end
			ST_QSQ: begin
				mul_en = 1'b1;
			end
			ST_YSQ: begin
				mul_en = 1'b1;
				mul_a  = y_q;
				mul_b  = y_q;
				add_a  = qe_q;
			end
			ST_DSQ: begin
				mul_en = 1'b1;
				mul_a  = d_w;
				mul_b  = d_w;
				add_a  = ye_q;
			end
			ST_DIFF: begin
				add_a = diff_q;
				if (diff_abs) begin
					add_b = ACC_W'((d_w < 0) ? -d_w : d_w);
				end else if (prod > PROD_W'(ACC_MAX)) begin
					add_b = ACC_MAX;
				end else begin
					add_b = prod64;
				end
			end
			ST_FIN: begin
				sq_start = (metric_q == MET_COSINE) || (metric_q == MET_EUCLID) ||
					(metric_q == MET_DOT && norm_q);
				if (metric_q == MET_COSINE) sq_x = qe_q[ACC_W-1] ? '0 : ACC_W'(qe_q);
				else if (metric_q == MET_EUCLID) sq_x = diff_q[ACC_W-1] ? '0 : ACC_W'(diff_q);
				else sq_x = ye_q[ACC_W-1] ? '0 : ACC_W'(ye_q);
			end
			ST_SQRT_A: begin
				sq_start = sq_stat.done && (metric_q == MET_COSINE);
				sq_x     = ye_q[ACC_W-1] ? '0 : ACC_W'(ye_q);
			end
			ST_SQRT_B: begin
				div_start = sq_stat.done && !zero_norm && (metric_q == MET_DOT);
				div_num   = NUM_W'(mag) << SH_Q1;
				div_den   = ACC_W'(sq_root);
			end
			ST_DEN_MUL: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(nq_q);
				mul_b  = MUL_W'(sq_root);
			end
			ST_DEN: begin
				div_start = !cos_full;
			end
			default: begin
			end
		endcase
	end

	// result of the metrics that need no root or divide, and of euclidean from its root
	always_comb begin
		fin_direct = 1'b1;
		fin_r      = '0;
		if (metric_q == MET_DOT && !norm_q) begin
			fin_r = scale_q(cross_q, SH_Q2);
		end else if (metric_q == MET_MANHAT) begin
			fin_r = scale_q(diff_q, SH_Q1);
		end else if (metric_q == MET_SQEUCL) begin
			fin_r = scale_q(diff_q, SH_Q2);
		end else if (metric_q == MET_EUCLID) begin
			fin_direct = 1'b0;
			fin_r      = scale_q(ACC_W'(sq_root), SH_Q1);
		end else begin
			fin_direct = 1'b0;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			metric_q     <= MET_COSINE;
			norm_q       <= 1'b0;
			cross_q      <= '0;
			qe_q         <= '0;
			ye_q         <= '0;
			diff_q       <= '0;
			sat_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_METRIC: metric_q <= cfg_data;
					CFG_NORM:   norm_q   <= cfg_data[0];
					default:    ;
				endcase
			end
			if (m_axis_tready && !(state_q == ST_OUT && out_free)) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_DEQ: begin
					if (step_q != '0 && (ysum > VMAX || ysum < VMIN)) sat_q <= 1'b1;
				end
				ST_QSQ: begin
					cross_q <= add_r.val;
					if (add_r.sat && (metric_q == MET_COSINE || metric_q == MET_DOT))
						sat_q <= 1'b1;
				end
				ST_YSQ: begin
					qe_q <= add_r.val;
					if (add_r.sat && metric_q == MET_COSINE) sat_q <= 1'b1;
				end
				ST_DSQ: begin
					ye_q <= add_r.val;
					if (add_r.sat && use_ye) sat_q <= 1'b1;
				end
				ST_DIFF: begin
					if (diff_sq || diff_abs) begin
						diff_q <= add_r.val;
						if (add_r.sat || (diff_sq && prod > PROD_W'(ACC_MAX))) sat_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cross_q     <= '0;
						qe_q        <= '0;
						ye_q        <= '0;
						diff_q      <= '0;
						sat_q       <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_q    <= MUL_W'($signed(s_axis_tdata[OFS_QUERY +: VALUE_WIDTH]));
			code_q <= s_axis_tdata[OFS_CODE +: CODE_W];
			min_q  <= MUL_W'($signed(s_axis_tdata[OFS_MIN +: VALUE_WIDTH]));
			step_q <= MUL_W'($signed(s_axis_tdata[OFS_STEP +: VALUE_WIDTH]));
			last_q <= s_axis_tlast;
		end
		if (state_q == ST_DEQ) begin
			if (step_q == '0) y_q <= min_q;
			else if (ysum > VMAX) y_q <= VMAX[MUL_W-1:0];
			else if (ysum < VMIN) y_q <= VMIN[MUL_W-1:0];
			else y_q <= ysum[MUL_W-1:0];
		end
		if (state_q == ST_SQRT_A && sq_stat.done) nq_q <= sq_root;
		if (state_q == ST_FIN) begin
			if (fin_direct) begin
				res_dist_q   <= fin_r.val;
				res_status_q <= (sat_q || fin_r.sat) ? STAT_SAT : STAT_OK;
			end else begin
				res_dist_q   <= '0;
				res_status_q <= STAT_BADMET;
			end
		end
		if (state_q == ST_SQRT_A && sq_stat.done && metric_q == MET_EUCLID) begin
			res_dist_q   <= fin_r.val;
			res_status_q <= (sat_q || fin_r.sat) ? STAT_SAT : STAT_OK;
		end
		if (state_q == ST_SQRT_B && sq_stat.done && zero_norm) begin
			res_dist_q   <= '0;
			res_status_q <= STAT_ZERONORM;
		end
		if (state_q == ST_DEN && cos_full) begin
			res_dist_q   <= neg ? (ONE_Q32 + ONE_Q32) : '0;
			res_status_q <= sat_q ? STAT_SAT : STAT_OK;
		end
		if (state_q == ST_DIV && div_stat.done) begin
			if (metric_q == MET_COSINE) begin
				res_dist_q   <= neg ? (ONE_Q32 + cos_sim) : (ONE_Q32 - cos_sim);
				res_status_q <= sat_q ? STAT_SAT : STAT_OK;
			end else if (div_quot[NUM_W-1:ACC_W-1] != '0) begin
				res_dist_q   <= neg ? ACC_MIN : ACC_MAX;
				res_status_q <= STAT_SAT;
			end else begin
				res_dist_q   <= neg ? -dot_q0 : dot_q0;
				res_status_q <= sat_q ? STAT_SAT : STAT_OK;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			out_dist_q   <= res_dist_q;
			out_status_q <= res_status_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_dist_q;
	assign m_axis_tuser  = out_status_q;

`include "assert_macros.svh"

	`SQ_ASSERT_IMPL(a_div_in_div_state, div_stat.busy, state_q == ST_DIV)
	`SQ_ASSERT_IMPL(a_sqrt_in_root_state, sq_stat.busy,
		state_q == ST_SQRT_A || state_q == ST_SQRT_B)
	`SQ_ASSERT_IMPL(a_no_dist_on_fault,
		m_axis_tvalid && (m_axis_tuser == STAT_ZERONORM || m_axis_tuser == STAT_BADMET),
		m_axis_tdata == '0)

endmodule

[rtl/core/sq8dvd_mul.sv]
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module sq8dvd_mul (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [sq8dvd_pkg::MUL_W-1:0]    a,
	input  logic signed [sq8dvd_pkg::MUL_W-1:0]    b,
	output logic signed [sq8dvd_pkg::PROD_W-1:0]   p
);
	import sq8dvd_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign p = p_q;

endmodule

[rtl/core/sq8dvd_isqrt.sv]
// Iterative integer square root; a start while busy abandons the root in work and begins anew.
`timescale 1ns / 1ps
module sq8dvd_isqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [sq8dvd_pkg::ACC_W-1:0]       x,
	output sq8dvd_pkg::unit_stat_t             stat,
	output logic [sq8dvd_pkg::ROOT_W-1:0]      root
);
	import sq8dvd_pkg::*;

	logic [ACC_W-1:0] x_q;
	logic [ACC_W-1:0] res_q;
	logic [ACC_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [ACC_W-1:0] trial;
	logic             ge;

	assign trial = res_q + bit_q;
	assign ge    = (x_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == ACC_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			res_q <= '0;
			bit_q <= ACC_W'(1) << (ACC_W - 2);
		end else if (busy_q) begin
			if (ge) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = res_q[ROOT_W-1:0];

endmodule

[rtl/core/sq8dvd_div.sv]
// Restoring shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sq8dvd_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sq8dvd_pkg::NUM_W-1:0]      num,
	input  logic [sq8dvd_pkg::ACC_W-1:0]      den,
	output sq8dvd_pkg::unit_stat_t            stat,
	output logic [sq8dvd_pkg::NUM_W-1:0]      quot
);
	import sq8dvd_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [ACC_W-1:0] rem_q;
	logic [ACC_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [ACC_W:0]   trial;
	logic [ACC_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = num_q;

endmodule

[verif/sq8_dequant_vector_distance_top_tb.sv]
// Self-checking testbench for the SQ8 dequantizing vector distance top level.
`timescale 1ns / 1ps
module sq8_dequant_vector_distance_top_tb;
	import sq8dvd_pkg::*;

	typedef struct {
		logic signed [31:0] qv;
		logic [7:0]         code;
		logic signed [31:0] lmin;
		logic signed [31:0] lstep;
		logic               last;
	} dim_t;

	typedef struct {
		logic [63:0] dval;
		logic [1:0]  stat;
	} dist_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [2:0]   cfg_data;

	dim_t  dim_q[$];
	dist_t dist_q[$];
	dim_t  cur_dim;
	int    errors;
	int    send_gap;
	int    recv_stall;
	bit    calm;

	// shadow of registers and accumulators
	logic [2:0] sh_metric;
	logic       sh_norm;
	longint     p_cross, p_qe, p_ye, p_diff;
	bit         p_sat;

	sq8_dequant_vector_distance_top u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	function automatic longint sadd(input longint a, input longint b, inout bit s);
		logic signed [64:0] t;
		t = {a[63], a} + {b[63], b};
		if (t[64] != t[63]) begin
			s = 1'b1;
			return t[64] ? ACC_MIN : ACC_MAX;
		end
		return t[63:0];
	endfunction

	function automatic longint unsigned root64(input longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned mag64(input longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint unsigned pos_root(input longint v);
		return root64(v < 0 ? 64'd0 : 64'(v));
	endfunction

	// rescale by 16 bits up, clamping
	function automatic longint up16(input longint v, inout bit s);
		longint hi;
		hi = ACC_MAX >>> 16;
		if (v > hi) begin
			s = 1'b1;
			return ACC_MAX;
		end
		if (v < -hi - 1) begin
			s = 1'b1;
			return ACC_MIN;
		end
		return v <<< 16;
	endfunction

	function automatic dist_t metric_result();
		dist_t r;
		bit s;
		longint unsigned nq, ny, den, mg, rem, sim, q0;
		r.dval = 0;
		s = p_sat;
		case (sh_metric)
			MET_COSINE: begin
				nq = pos_root(p_qe);
				ny = pos_root(p_ye);
				if (nq == 0 || ny == 0) begin
					r.stat = STAT_ZERONORM;
					return r;
				end
				den = nq * ny;
				mg = mag64(p_cross);
				sim = 0;
				if (mg >= den) begin
					sim = 64'd1 << 32;
				end else begin
					rem = mg;
					for (int i = 0; i < 32; i++) begin
						rem <<= 1;
						sim <<= 1;
						if (rem >= den) begin
							rem -= den;
							sim |= 1;
						end
					end
				end
				r.dval = (64'sd1 <<< 32) - (p_cross < 0 ? -longint'(sim) : longint'(sim));
			end
			MET_DOT: begin
				if (sh_norm) begin
					ny = pos_root(p_ye);
					if (ny == 0) begin
						r.stat = STAT_ZERONORM;
						return r;
					end
					mg = mag64(p_cross);
					q0 = mg / ny;
					rem = mg % ny;
					if (q0 > 64'(ACC_MAX >>> 16)) begin
						s = 1'b1;
						r.dval = p_cross < 0 ? ACC_MIN : ACC_MAX;
					end else begin
						q0 <<= 16;
						for (int i = 16; i > 0; i--) begin
							rem <<= 1;
							if (rem >= ny) begin
								rem -= ny;
								q0 |= 64'd1 << (i - 1);
							end
						end
						r.dval = p_cross < 0 ? -longint'(q0) : longint'(q0);
					end
				end else begin
					r.dval = p_cross;
				end
			end
			MET_EUCLID: r.dval = up16(longint'(pos_root(p_diff)), s);
			MET_MANHAT: r.dval = up16(p_diff, s);
			MET_SQEUCL: r.dval = p_diff;
			default: begin
				r.stat = STAT_BADMET;
				return r;
			end
		endcase
		r.stat = s ? STAT_SAT : STAT_OK;
		return r;
	endfunction

	task automatic accumulate_dim(input dim_t d);
		longint y, q, df, t;
		longint unsigned m;
		bit sc, sq, sy, sd, use_ye;
		sc = 0; sq = 0; sy = 0; sd = 0;
		use_ye = (sh_metric == MET_COSINE) || (sh_metric == MET_DOT && sh_norm);
		q = d.qv;
		if (d.lstep == 0) begin
			y = d.lmin;
		end else begin
			y = longint'(d.lmin) + ((longint'(d.lstep) * longint'(2 * d.code + 1)) >>> 1);
			if (y > 64'sh7fffffff) begin
				y = 64'sh7fffffff;
				p_sat = 1'b1;
			end
			if (y < -64'sh80000000) begin
				y = -64'sh80000000;
				p_sat = 1'b1;
			end
		end
		p_cross = sadd(p_cross, q * y, sc);
		p_qe = sadd(p_qe, q * q, sq);
		p_ye = sadd(p_ye, y * y, sy);
		df = q - y;
		if (sh_metric == MET_MANHAT) begin
			p_diff = sadd(p_diff, df < 0 ? -df : df, sd);
		end else if (sh_metric == MET_EUCLID || sh_metric == MET_SQEUCL) begin
			m = mag64(df);
			m = m * m;
			if (m > 64'(ACC_MAX)) begin
				sd = 1'b1;
				t = ACC_MAX;
			end else begin
				t = m;
			end
			p_diff = sadd(p_diff, t, sd);
		end
		if ((sc && sh_metric <= MET_DOT) || (sq && sh_metric == MET_COSINE) || (sy && use_ye) || sd)
			p_sat = 1'b1;
		if (d.last) begin
			dist_q.push_back(metric_result());
			p_cross = 0; p_qe = 0; p_ye = 0; p_diff = 0; p_sat = 0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			send_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) accumulate_dim(cur_dim);
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (dim_q.size() > 0) begin
				cur_dim = dim_q.pop_front();
				s_axis_tdata <= {cur_dim.lstep, cur_dim.lmin, cur_dim.code, cur_dim.qv};
				s_axis_tlast <= cur_dim.last;
				s_axis_tvalid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		dist_t w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (dist_q.size() == 0) begin
					report("unexpected word", m_axis_tdata, 64'd0);
				end else begin
					w = dist_q.pop_front();
					if (m_axis_tdata !== w.dval) report("distance", m_axis_tdata, w.dval);
					if (m_axis_tuser !== w.stat)
						report("status", 64'(m_axis_tuser), 64'(w.stat));
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				recv_stall <= pick_gap();
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [31:0] pick_value(input int kind);
		case (kind)
			0: return $signed($urandom_range(1 << 19)) - (1 << 18);
			1: return $urandom;
			default: begin
				case ($urandom_range(4))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'h0;
					3: return 32'h1;
					default: return 32'hffffffff;
				endcase
			end
		endcase
	endfunction

	function automatic int value_kind();
		int r;
		r = $urandom_range(99);
		return r < 85 ? 0 : (r < 95 ? 1 : 2);
	endfunction

	task automatic push_dim(input logic [31:0] q, input logic [7:0] c, input logic [31:0] mn,
			input logic [31:0] st, input logic last);
		dim_t d;
		d.qv = q; d.code = c; d.lmin = mn; d.lstep = st; d.last = last;
		dim_q.push_back(d);
	endtask

	task automatic push_vector(input int len);
		logic [31:0] st;
		for (int i = 0; i < len; i++) begin
			st = ($urandom_range(9) == 0) ? 32'h0 : pick_value(value_kind()) >>> 4;
			if ($urandom_range(19) == 0) st = pick_value(1);
			push_dim(pick_value(value_kind()), 8'($urandom), pick_value(value_kind()), st,
				i == len - 1);
		end
	endtask

	task automatic drain();
		while (dim_q.size() > 0 || s_axis_tvalid || dist_q.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [2:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_METRIC) sh_metric = val;
		else sh_norm = val[0];
	endtask

	initial begin
		logic [2:0] mlist[9];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		errors = 0;
		calm = 1'b0;
		sh_metric = MET_COSINE; sh_norm = 1'b0;
		p_cross = 0; p_qe = 0; p_ye = 0; p_diff = 0; p_sat = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, cosine from reset
		push_dim(32'h00010000, 8'd0, 32'h0, 32'h00008000, 1'b0);
		push_dim(32'hffff0000, 8'd255, 32'hfffe0000, 32'h00000100, 1'b1);
		push_dim(32'h0, 8'd17, 32'h00030000, 32'h0, 1'b1);          // zero step
		push_dim(32'h0, 8'd3, 32'h00010000, 32'h00001000, 1'b1);    // zero query norm
		push_dim(32'h7fffffff, 8'd255, 32'h7fffffff, 32'h7fffffff, 1'b1); // clamp high
		push_dim(32'h80000000, 8'd255, 32'h80000000, 32'h80000000, 1'b1); // clamp low
		for (int i = 0; i < 4; i++)                                   // accumulator limits
			push_dim(32'h80000000, 8'd0, 32'h80000000, 32'h0, i == 3);
		push_dim(32'h00020000, 8'd128, 32'hffff8000, 32'hffffff00, 1'b1);
		write_reg(CFG_NORM, 3'd1);
		write_reg(CFG_METRIC, MET_DOT);
		push_dim(32'h7fffffff, 8'd0, 32'h00000001, 32'h0, 1'b1);    // huge after divide
		push_dim(32'h00010000, 8'd0, 32'h0, 32'h0, 1'b1);           // zero candidate norm
		push_vector(3);
		write_reg(CFG_METRIC, MET_EUCLID);
		push_dim(32'h7fffffff, 8'd0, 32'h80000000, 32'h0, 1'b0);
		push_dim(32'h00050000, 8'd9, 32'h0, 32'h00001000, 1'b0);
		write_reg(CFG_METRIC, MET_MANHAT);                            // change mid-vector
		push_dim(32'h7fffffff, 8'd0, 32'h80000000, 32'h0, 1'b1);
		for (int i = 0; i < 3; i++)                                   // manhattan, largest differences
			push_dim(32'h7fffffff, 8'd0, 32'h80000000, 32'h0, i == 2);
		write_reg(CFG_METRIC, MET_SQEUCL);
		push_vector(2);
		write_reg(CFG_METRIC, 3'd7);
		push_vector(2);
		write_reg(CFG_METRIC, 3'd5);
		push_vector(1);

		// random phases
		mlist = '{MET_COSINE, MET_DOT, MET_DOT, MET_EUCLID, MET_MANHAT, MET_SQEUCL,
			MET_COSINE, 3'd6, MET_DOT};
		for (int ph = 0; ph < 12; ph++) begin
			int n;
			write_reg(CFG_METRIC, ph < 9 ? mlist[ph] : 3'($urandom_range(7)));
			write_reg(CFG_NORM, ph == 2 ? 3'd0 : 3'($urandom_range(1)));
			calm = (ph % 4 == 3);
			n = 0;
			while (n < 150) begin
				int len;
				len = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
				push_vector(len);
				n += len;
			end
		end
		drain();
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sq8dvd_pkg.sv
rtl/core/sq8dvd_mul.sv
rtl/core/sq8dvd_isqrt.sv
rtl/core/sq8dvd_div.sv
rtl/core/sq8_dequant_vector_distance_top.sv
verif/sq8_dequant_vector_distance_top_tb.sv
